// ===== rtl/core/vptw_pkg.sv =====
// package for the vertex projection unit: fixed-point format, widths, codes
// and the shared payload types; no dependencies
package vptw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W = 32;
  localparam int QW = W + FRAC_BITS;
  localparam int DIV_STEPS = QW;
  localparam logic signed [W-1:0] ONE_FX = W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [W-1:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [W-1:0] MIN32 = 32'sh80000000;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_POINT = 1'b1;
  localparam logic SEL_MODEL = 1'b0;
  localparam logic SEL_PROJ = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_WZERO = 1'b1;

  localparam logic [3:0] REG_LEFT = 4'h0;
  localparam logic [3:0] REG_TOP = 4'h4;
  localparam logic [3:0] REG_WIDTH = 4'h8;
  localparam logic [3:0] REG_HEIGHT = 4'hc;

  typedef logic signed [W-1:0] fx_t;
  typedef fx_t vec4_t [4];

  // one divider lane: partial remainder, quotient and divisor, plus the sign of the result
  typedef struct packed {
    logic [QW-1:0] rem;
    logic [QW-1:0] quo;
    logic [W-1:0] den;
    logic neg;
  } div_lane_t;

  function automatic fx_t sat32(input logic signed [71:0] v);
    if (v > 72'(MAX32)) return MAX32;
    if (v < 72'(MIN32)) return MIN32;
    return fx_t'(v[W-1:0]);
  endfunction

endpackage

// ===== rtl/core/vertex_project_to_window_unit.sv =====
// vertex projection top level: model and projection transform, perspective divide,
// viewport map; uses vptw_pkg and vptw_matvec
// pipeline from the accepting edge to out_tvalid: entry register,
// 4 matrix stages, 49 divider stages (load plus 48 steps), 3 map stages, output register
// throughput: one item per cycle; the whole pipe holds while a result waits on out_tready
// reset: synchronous rst_n clears valids, identity matrices, viewport 0,0,640,480
module vertex_project_to_window_unit
  import vptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: matrix_select, entry_index, entry_value, point_x, point_y, point_z, zero pad
  input  logic [135:0] in_tdata,
  // tuser: kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: win_x, win_y, win_z
  output logic [95:0] out_tdata,
  // tuser: status
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // entry register, 4 matrix stages, divider load plus steps, 3 map stages
  localparam int NS = 9 + DIV_STEPS;

  // viewport registers
  logic signed [15:0] vp_left_r, vp_top_r;
  logic [15:0] vp_width_r, vp_height_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_left_r <= '0;
      vp_top_r <= '0;
      vp_width_r <= 16'd640;
      vp_height_r <= 16'd480;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        REG_LEFT:   vp_left_r <= cfg_pwdata[15:0];
        REG_TOP:    vp_top_r <= cfg_pwdata[15:0];
        REG_WIDTH:  vp_width_r <= cfg_pwdata[15:0];
        REG_HEIGHT: vp_height_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_LEFT:   cfg_prdata = 32'(vp_left_r);
      REG_TOP:    cfg_prdata = 32'(vp_top_r);
      REG_WIDTH:  cfg_prdata = {16'd0, vp_width_r};
      REG_HEIGHT: cfg_prdata = {16'd0, vp_height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // the whole pipe moves together; an empty or draining output slot lets it advance
  logic adv;
  logic vld_r [NS];
  logic out_vld_r;
  assign adv = !out_vld_r || out_tready;
  assign in_tready = adv;

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // input fields
  logic in_sel;
  logic [3:0] in_idx;
  fx_t in_val, in_x, in_y, in_z;
  assign in_sel = in_tdata[0];
  assign in_idx = in_tdata[4:1];
  assign in_val = in_tdata[36:5];
  assign in_x = in_tdata[68:37];
  assign in_y = in_tdata[100:69];
  assign in_z = in_tdata[132:101];

  // matrices: loads write at entry, points read the current values at entry;
  // the projection matrix is captured alongside the point for stage 2
  fx_t model_r [16];
  fx_t proj_r [16];
  fx_t proj_s1_r [16], proj_s2_r [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        model_r[i] <= (i % 5 == 0) ? ONE_FX : '0;
        proj_r[i] <= (i % 5 == 0) ? ONE_FX : '0;
      end
    end else if (in_fire && in_tuser == KIND_LOAD) begin
      if (in_sel == SEL_PROJ) proj_r[in_idx] <= in_val;
      else model_r[in_idx] <= in_val;
    end
  end

  // stage valid chain; only point items carry a valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_fire && in_tuser == KIND_POINT;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  fx_t model_s_r [16];
  fx_t pt_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      model_s_r <= model_r;
      proj_s1_r <= proj_r;
      proj_s2_r <= proj_s1_r;
      pt_r[0] <= in_x;
      pt_r[1] <= in_y;
      pt_r[2] <= in_z;
      pt_r[3] <= ONE_FX;
    end
  end

  // first transform occupies stages 1..2, second 3..4 (after the captured vector)
  fx_t t_vec [4], p_vec [4];
  vptw_matvec u_model (.clk(clk), .en(adv), .mat(model_s_r), .vin(pt_r), .vout(t_vec));
  vptw_matvec u_proj  (.clk(clk), .en(adv), .mat(proj_s2_r), .vin(t_vec), .vout(p_vec));

  // restoring dividers for x, y, z: one quotient bit per stage
  div_lane_t lane_r [DIV_STEPS+1][3];
  logic wz_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      wz_r[0] <= (p_vec[3] == '0);
      for (int k = 0; k < 3; k++) begin
        lane_r[0][k].rem <= '0;
        lane_r[0][k].quo <= QW'({(p_vec[k][W-1] ? -p_vec[k] : p_vec[k]), {FRAC_BITS{1'b0}}});
        lane_r[0][k].den <= p_vec[3][W-1] ? W'(-p_vec[3]) : W'(p_vec[3]);
        lane_r[0][k].neg <= p_vec[k][W-1] ^ p_vec[3][W-1];
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
        wz_r[s+1] <= wz_r[s];
        for (int k = 0; k < 3; k++) begin
          logic [QW:0] trial;
          trial = {lane_r[s][k].rem, lane_r[s][k].quo[QW-1]} - (QW+1)'(lane_r[s][k].den);
          lane_r[s+1][k].den <= lane_r[s][k].den;
          lane_r[s+1][k].neg <= lane_r[s][k].neg;
          if (!trial[QW]) begin
            lane_r[s+1][k].rem <= trial[QW-1:0];
            lane_r[s+1][k].quo <= {lane_r[s][k].quo[QW-2:0], 1'b1};
          end else begin
            lane_r[s+1][k].rem <= {lane_r[s][k].rem[QW-2:0], lane_r[s][k].quo[QW-1]};
            lane_r[s+1][k].quo <= {lane_r[s][k].quo[QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // map stages: signed saturated quotient, half map, viewport scale
  fx_t q_r [3], n_r [3];
  logic wz_m1_r, wz_m2_r, wz_m3_r;
  logic signed [63:0] wx_r, wy_r;
  fx_t nz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [QW+1:0] sq;
        sq = lane_r[DIV_STEPS][k].neg ? -$signed({2'b0, lane_r[DIV_STEPS][k].quo})
                                      : $signed({2'b0, lane_r[DIV_STEPS][k].quo});
        q_r[k] <= sat32(72'(sq));
        n_r[k] <= sat32(72'((33'(q_r[k]) + 33'(ONE_FX)) >>> 1));
      end
      wz_m1_r <= wz_r[DIV_STEPS];
      wz_m2_r <= wz_m1_r;
      wx_r <= 64'(n_r[0]) * $signed({48'd0, vp_width_r})
            + (64'(vp_left_r) <<< FRAC_BITS);
      wy_r <= 64'(n_r[1]) * $signed({48'd0, vp_height_r})
            + (64'(vp_top_r) <<< FRAC_BITS);
      nz_r <= n_r[2];
      wz_m3_r <= wz_m2_r;
    end
  end

  // output register
  fx_t ox_r, oy_r, oz_r;
  logic ost_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= vld_r[NS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= wz_m3_r ? '0 : sat32(72'(wx_r));
      oy_r <= wz_m3_r ? '0 : sat32(72'(wy_r));
      oz_r <= wz_m3_r ? '0 : nz_r;
      ost_r <= wz_m3_r ? STATUS_WZERO : STATUS_OK;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {oz_r, oy_r, ox_r};
  assign out_tuser = ost_r;

endmodule

// ===== rtl/core/vptw_matvec.sv =====
// two-stage 4x4 fixed-point matrix times vector: products, then floored sum
// uses vptw_pkg
module vptw_matvec
  import vptw_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  fx_t  mat [16],
  input  fx_t  vin [4],
  output fx_t  vout [4]
);

  logic signed [63:0] prod_r [16];
  fx_t res_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 16; i++) begin
        prod_r[i] <= 64'(mat[i]) * 64'(vin[i % 4]);
      end
      for (int r = 0; r < 4; r++) begin
        // arithmetic shift is the floor
        res_r[r] <= sat32(72'(prod_r[r*4] >>> FRAC_BITS) + 72'(prod_r[r*4+1] >>> FRAC_BITS)
                        + 72'(prod_r[r*4+2] >>> FRAC_BITS) + 72'(prod_r[r*4+3] >>> FRAC_BITS));
      end
    end
  end

  assign vout = res_r;

endmodule

// ===== rtl/core/vptw_checker.sv =====
// port-level checker for the vertex projection unit, bound to the top level
// uses vptw_pkg
module vptw_checker
  import vptw_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [95:0] out_tdata,
  input logic out_tuser,
  input logic cfg_pready
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_WZERO |-> out_tdata == '0)
    else $error("zero w result not cleared");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind vertex_project_to_window_unit vptw_checker u_vptw_checker (.*);

// ===== bench/vertex_project_to_window_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for vertex_project_to_window_unit: matrix loads, point projection,
// viewport registers over apb; depends on vptw_pkg and the rtl top level
module vertex_project_to_window_unit_test;
  import vptw_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam int SETTLE_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] win_z;
    logic status;
  } window_pt_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [135:0] in_tdata;   // matrix_select, entry_index, entry_value, x, y, z, zero pad
  logic in_tuser;           // kind
  logic out_tvalid;
  logic out_tready;
  logic [95:0] out_tdata;   // win_x, win_y, win_z
  logic out_tuser;          // status
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  vertex_project_to_window_unit uut (.*);

  // predictor state: both matrices and the viewport
  logic signed [31:0] model_mx [16];
  logic signed [31:0] proj_mx [16];
  logic signed [15:0] vp_left, vp_top;
  logic [15:0] vp_width, vp_height;

  window_pt_t expected_points [$];
  int mismatches;
  longint cycle_count = 0;
  bit stall_enable;   // when clear the receiver never stalls
  int stall_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // global watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("vertex_project_to_window_unit_test NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp32(input logic signed [71:0] v);
    if (v > 72'sh7fffffff) return 32'sh7fffffff;
    if (v < -72'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // arithmetic shift floors, which is what the block wants for products
  function automatic void transform4(input logic signed [31:0] mx [16],
                                     input logic signed [31:0] v [4],
                                     output logic signed [31:0] r [4]);
    logic signed [71:0] acc;
    logic signed [71:0] prod;
    for (int row = 0; row < 4; row++) begin
      acc = 0;
      for (int col = 0; col < 4; col++) begin
        prod = 72'(mx[row*4+col]) * 72'(v[col]);
        acc += prod >>> FB;
      end
      r[row] = clamp32(acc);
    end
  endfunction

  // divide truncating toward zero, then (q + 1.0) / 2 floored
  function automatic logic signed [31:0] ndc_to_unit(input logic signed [31:0] a,
                                                    input logic signed [31:0] w);
    logic signed [71:0] num;
    logic signed [71:0] q;
    num = 72'(a) <<< FB;
    q = num / 72'(w);
    q = 72'(clamp32(q)) + (72'sd1 <<< FB);
    return clamp32(q >>> 1);
  endfunction

  function automatic window_pt_t project_point(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
    logic signed [31:0] v [4];
    logic signed [31:0] t [4];
    logic signed [31:0] p [4];
    logic signed [31:0] nx, ny;
    window_pt_t r;
    v[0] = px; v[1] = py; v[2] = pz; v[3] = 32'sd1 <<< FB;
    transform4(model_mx, v, t);
    transform4(proj_mx, t, p);
    r = '0;
    if (p[3] == 0) begin
      r.status = STATUS_WZERO;
      return r;
    end
    nx = ndc_to_unit(p[0], p[3]);
    ny = ndc_to_unit(p[1], p[3]);
    r.win_z = ndc_to_unit(p[2], p[3]);
    r.win_x = clamp32(72'(nx) * $signed({56'd0, vp_width}) + (72'(vp_left) <<< FB));
    r.win_y = clamp32(72'(ny) * $signed({56'd0, vp_height}) + (72'(vp_top) <<< FB));
    r.status = STATUS_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    window_pt_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], 0);
      end else begin
        e = expected_points.pop_front();
        if (out_tdata[31:0] !== e.win_x) report_mismatch("win_x", out_tdata[31:0], e.win_x);
        if (out_tdata[63:32] !== e.win_y) report_mismatch("win_y", out_tdata[63:32], e.win_y);
        if (out_tdata[95:64] !== e.win_z) report_mismatch("win_z", out_tdata[95:64], e.win_z);
        if (out_tuser !== e.status) report_mismatch("status", out_tuser, e.status);
      end
    end
  end

  // mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if (!stall_enable) out_tready <= 1'b1;
    else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_tready <= 1'b0;
      stall_left <= int'($urandom_range(10, 40));
    end else if ($urandom_range(0, 99) < 60) out_tready <= 1'b1;
    else out_tready <= 1'($urandom_range(0, 1));
  end

  // gap after an item: usually none, sometimes short, rarely long
  function automatic int gap_len();
    if ($urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 40))
                                        : int'($urandom_range(1, 3));
  endfunction

  // send one item; predictor runs at acceptance; valid stays up for back-to-back items
  task automatic send_item(input logic kind, input logic sel, input logic [3:0] idx,
                           input logic [31:0] val, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz);
    int n;
    in_tuser <= kind;
    in_tdata <= {3'd0, pz, py, px, val, idx, sel};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_LOAD) begin
      if (sel == SEL_PROJ) proj_mx[idx] = val;
      else model_mx[idx] = val;
    end else begin
      expected_points.push_back(project_point(px, py, pz));
    end
    @(negedge clk);
    n = gap_len();
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic load_entry(input logic sel, input logic [3:0] idx, input logic [31:0] val);
    send_item(KIND_LOAD, sel, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
    send_item(KIND_POINT, 1'($urandom), 4'($urandom), $urandom, px, py, pz);
  endtask

  // drain, then let any trailing load settle before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [15:0] value);
    logic [31:0] rb;
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= {16'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    // straight into the read-back setup phase, select stays high
    cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (addr)
      REG_LEFT: vp_left = value;
      REG_TOP: vp_top = value;
      REG_WIDTH: vp_width = value;
      default: vp_height = value;
    endcase
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rb = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    if (rb[15:0] !== value) report_mismatch("register readback", rb, {16'd0, value});
  endtask

  task automatic set_viewport(input logic [15:0] l, input logic [15:0] t,
                              input logic [15:0] w, input logic [15:0] h);
    wait_idle();
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic logic [31:0] rand_small_fx();
    // values in about -4..4 so projections land on screen often
    return $signed($urandom_range(0, 524288)) - 32'sd262144;
  endfunction

  // identity path, extremes of the coordinates
  task automatic test_identity_points();
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
  endtask

  // w of zero through the projection bottom row, then perspective
  task automatic test_w_zero_and_perspective();
    load_entry(SEL_PROJ, 4'd15, 0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    load_entry(SEL_PROJ, 4'd14, 32'hffff_0000);   // w = -z
    send_point(32'h0001_0000, 32'h0001_0000, 32'hfffe_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);  // w zero again
    load_entry(SEL_MODEL, 4'd3, 32'h7fff_ffff);   // huge translation saturates
    send_point(32'h7fff_ffff, 0, 32'hffff_0000);
    load_entry(SEL_MODEL, 4'd3, 0);
    load_entry(SEL_PROJ, 4'd14, 0);
    load_entry(SEL_PROJ, 4'd15, 32'h0001_0000);
    load_entry(SEL_MODEL, 4'd0, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h0000_8000, 32'h0000_4000);
    load_entry(SEL_MODEL, 4'd0, 32'h0001_0000);
  endtask

  // random matrices and points: mostly small values, some full-range noise
  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: load_entry(1'($urandom), 4'($urandom), $urandom);
        1, 2: load_entry(1'($urandom), 4'($urandom), rand_small_fx());
        3: send_point($urandom, $urandom, $urandom);
        default: send_point(rand_small_fx(), rand_small_fx(), rand_small_fx());
      endcase
    end
  endtask

  task automatic restore_identity();
    for (int i = 0; i < 16; i++) begin
      load_entry(SEL_MODEL, 4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
      load_entry(SEL_PROJ, 4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      model_mx[i] = (i % 5 == 0) ? 32'sh0001_0000 : 0;
      proj_mx[i] = model_mx[i];
    end
    vp_left = 0; vp_top = 0; vp_width = 640; vp_height = 480;
    mismatches = 0;
    stall_enable = 0;
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    test_identity_points();
    test_w_zero_and_perspective();
    stall_enable = 1;
    test_random_stream(200);
    set_viewport(16'h8000, 16'h7fff, 16'hffff, 16'h0000);
    test_random_stream(150);
    set_viewport(16'h7fff, 16'h8000, 16'h0000, 16'hffff);
    restore_identity();
    test_random_stream(150);
    set_viewport(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    stall_enable = 0;
    test_random_stream(100);
    stall_enable = 1;
    set_viewport(16'd10, 16'hfff6, 16'd1920, 16'd1080);
    test_random_stream(150);

    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("vertex_project_to_window_unit_test OK");
    end else begin
      $display("vertex_project_to_window_unit_test NOT OK");
    end
    $finish;
  end

endmodule
